// ===== rtl/core/mer_pkg.sv =====
// Package: shared widths, codes, and types for the midpoint ellipse rasterizer.
`timescale 1ns / 1ps

package mer_pkg;

    localparam int COORD_BITS   = 10;
    localparam int PIX_W        = COORD_BITS + 2;
    localparam int PT_W         = COORD_BITS + 1;
    localparam int SQ_W         = 2 * COORD_BITS;
    localparam int SLOPE_W      = 3 * COORD_BITS + 4;
    localparam int DEC_W        = 4 * COORD_BITS + 8;
    localparam int MUL_W        = 2 * COORD_BITS + 4;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int COLOR_W      = 8;
    localparam int IN_FIELDS_W  = 4 * COORD_BITS + 3 * COLOR_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * PIX_W + 3 * COLOR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [1:0] LAST_PIX = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ASQ,
        ST_BSQ,
        ST_BASQ,
        ST_INIT,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_C4,
        ST_C5,
        ST_C6,
        ST_C7,
        ST_STEP,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_ASQ,
        DP_BSQ,
        DP_BASQ,
        DP_INIT,
        DP_C1,
        DP_C2,
        DP_C3,
        DP_C4,
        DP_C5,
        DP_C6,
        DP_C7,
        DP_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       emit;
        logic [1:0] pix_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic r2;
        logic dx_lt_dy;
        logic y_zero;
    } dp_status_t;

    // Last field sits in the lowest bits.
    typedef struct packed {
        logic [COLOR_W-1:0]    blue;
        logic [COLOR_W-1:0]    green;
        logic [COLOR_W-1:0]    red;
        logic [COORD_BITS-1:0] center_y;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] semi_axis_y;
        logic [COORD_BITS-1:0] semi_axis_x;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [PIX_W-1:0]   pixel_y;
        logic [PIX_W-1:0]   pixel_x;
    } out_item_t;

    typedef struct packed {
        logic      done;
        logic      last;
        out_item_t data;
    } pixel_t;

endpackage

// ===== rtl/core/midpoint_ellipse_rasterizer_top.sv =====
// Top level of the midpoint ellipse rasterizer: stream ports, controller, datapath, output stage.
`timescale 1ns / 1ps

// Usage
//   Input channel (s_axis_*): one item per handshake. tuser[0] is the action:
//   0 starts a new ellipse from the semi-axes, center and color in tdata,
//   1 advances the running ellipse by one point. A step with no ellipse
//   running is accepted and dropped. A start always abandons the current one.
//   Output channel (m_axis_*): four mirrored pixels per point, one pixel per
//   item, in the order (+x,+y) (-x,+y) (+x,-y) (-x,-y). tlast marks the fourth,
//   tuser[0] marks every pixel of the final run (point with y = 0).
//   Sequence: a plain step updates the point as it is accepted and then
//   loads its four pixels; the next item may be taken with the fourth. A start
//   runs a^2, b^2 and b*a^2 through the shared multiplier, then sets the
//   initial decision, before its first pixels. The step that crosses into
//   region two first builds the quarter-unit decision in states C1 to C7
//   with the same multiplier and an accumulator.
//   Stall: pixels sit in a one-entry output register; while it is full and the
//   receiver holds tready low the controller waits in its emit state with
//   s_axis_tready low; it may take the next item as the last pixel is loaded.
//   Reset (aresetn low, synchronous): no ellipse running, output empty.

module midpoint_ellipse_rasterizer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, low bit up: semi_axis_x, semi_axis_y, center_x, center_y,
    // red_in, green_in, blue_in
    input  logic [mer_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: action
    input  logic [0:0]                        s_axis_tuser,
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, low bit up: pixel_x, pixel_y, red_out, green_out, blue_out
    output logic [mer_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,
    // tuser: ellipse_done
    output logic [0:0]                        m_axis_tuser
);

    mer_pkg::in_item_t   in_item;
    mer_pkg::dp_cmd_t    dp_cmd;
    mer_pkg::dp_status_t dp_status;
    mer_pkg::pixel_t     dp_pixel;
    mer_pkg::pixel_t     out_pixel;
    logic                out_load_ok;

    assign in_item = mer_pkg::in_item_t'(s_axis_tdata[mer_pkg::IN_FIELDS_W-1:0]);

    // Controller: owns busy flag, sequence state and pixel index.
    mer_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_axis_tvalid),
        .s_action    (s_axis_tuser[0]),
        .out_load_ok (out_load_ok),
        .status      (dp_status),
        .s_ready     (s_axis_tready),
        .cmd         (dp_cmd)
    );

    // Datapath: squares, slopes, decision, point and mirrored pixel.
    mer_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (dp_cmd),
        .in_item (in_item),
        .status  (dp_status),
        .pixel   (dp_pixel)
    );

    // One-entry output register decouples the receiver.
    mer_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (dp_cmd.emit),
        .d       (dp_pixel),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .q       (out_pixel),
        .load_ok (out_load_ok)
    );

    assign m_axis_tdata    = mer_pkg::OUT_TDATA_W'(out_pixel.data);
    assign m_axis_tlast    = out_pixel.last;
    assign m_axis_tuser[0] = out_pixel.done;

    // A pixel is only loaded when the output register has room.
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.emit |-> out_load_ok)
        else $error("pixel loaded into a full output register");

    // New ellipse setup only follows an accepted start item.
    a_load_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == mer_pkg::DP_LOAD) |->
            (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == mer_pkg::ACT_START)))
        else $error("setup started without an accepted start item");

    // No input is taken while the multiplier sequence runs.
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op != mer_pkg::DP_NOP && dp_cmd.op != mer_pkg::DP_LOAD &&
         dp_cmd.op != mer_pkg::DP_STEP) |-> !s_axis_tready)
        else $error("input ready during setup or changeover");

endmodule

// ===== rtl/core/mer_ctrl.sv =====
// Controller: sequences setup, region changeover, stepping and pixel emission.
`timescale 1ns / 1ps

module mer_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_action,
    input  logic                 out_load_ok,
    input  mer_pkg::dp_status_t  status,
    output logic                 s_ready,
    output mer_pkg::dp_cmd_t     cmd
);

    mer_pkg::state_t state_reg, state_next;
    logic [1:0]      k_reg, k_next;
    logic            busy_reg, busy_next;
    logic            take_item;
    logic            live;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mer_pkg::ST_IDLE;
            k_reg     <= 2'd0;
            busy_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        busy_next   = busy_reg;
        cmd.op      = mer_pkg::DP_NOP;
        cmd.emit    = 1'b0;
        cmd.pix_idx = k_reg;
        s_ready     = 1'b0;
        take_item   = 1'b0;
        live        = 1'b0;

        unique case (state_reg)
            mer_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                take_item = s_valid;
            end
            mer_pkg::ST_ASQ: begin
                cmd.op     = mer_pkg::DP_ASQ;
                state_next = mer_pkg::ST_BSQ;
            end
            mer_pkg::ST_BSQ: begin
                cmd.op     = mer_pkg::DP_BSQ;
                state_next = mer_pkg::ST_BASQ;
            end
            mer_pkg::ST_BASQ: begin
                cmd.op     = mer_pkg::DP_BASQ;
                state_next = mer_pkg::ST_INIT;
            end
            mer_pkg::ST_INIT: begin
                cmd.op     = mer_pkg::DP_INIT;
                state_next = mer_pkg::ST_EMIT;
                k_next     = 2'd0;
            end
            mer_pkg::ST_C1: begin
                cmd.op     = mer_pkg::DP_C1;
                state_next = mer_pkg::ST_C2;
            end
            mer_pkg::ST_C2: begin
                cmd.op     = mer_pkg::DP_C2;
                state_next = mer_pkg::ST_C3;
            end
            mer_pkg::ST_C3: begin
                cmd.op     = mer_pkg::DP_C3;
                state_next = mer_pkg::ST_C4;
            end
            mer_pkg::ST_C4: begin
                cmd.op     = mer_pkg::DP_C4;
                state_next = mer_pkg::ST_C5;
            end
            mer_pkg::ST_C5: begin
                cmd.op     = mer_pkg::DP_C5;
                state_next = mer_pkg::ST_C6;
            end
            mer_pkg::ST_C6: begin
                cmd.op     = mer_pkg::DP_C6;
                state_next = mer_pkg::ST_C7;
            end
            mer_pkg::ST_C7: begin
                cmd.op     = mer_pkg::DP_C7;
                state_next = mer_pkg::ST_STEP;
            end
            mer_pkg::ST_STEP: begin
                cmd.op     = mer_pkg::DP_STEP;
                state_next = mer_pkg::ST_EMIT;
                k_next     = 2'd0;
            end
            mer_pkg::ST_EMIT: begin
                if (out_load_ok) begin
                    cmd.emit = 1'b1;
                    k_next   = k_reg + 2'd1;
                    if (k_reg == mer_pkg::LAST_PIX) begin
                        // final pixel goes out; the next item may enter now
                        state_next = mer_pkg::ST_IDLE;
                        s_ready    = 1'b1;
                        take_item  = s_valid;
                        if (status.y_zero) begin
                            busy_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
                state_next = mer_pkg::ST_IDLE;
            end
        endcase

        live = busy_next;

        if (take_item) begin
            priority if (s_action == mer_pkg::ACT_START) begin
                cmd.op     = mer_pkg::DP_LOAD;
                busy_next  = 1'b1;
                state_next = mer_pkg::ST_ASQ;
            end else if (!live) begin
                // step with no ellipse running: dropped
                state_next = mer_pkg::ST_IDLE;
            end else if (status.r2 && status.y_zero) begin
                busy_next  = 1'b0;
                state_next = mer_pkg::ST_IDLE;
            end else if (!status.r2 && !status.dx_lt_dy) begin
                state_next = mer_pkg::ST_C1;
            end else begin
                cmd.op     = mer_pkg::DP_STEP;
                state_next = mer_pkg::ST_EMIT;
                k_next     = 2'd0;
            end
        end
    end

endmodule

// ===== rtl/core/mer_dp.sv =====
// Datapath: ellipse state registers, shared multiplier, step update, pixel mirror.
`timescale 1ns / 1ps

module mer_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mer_pkg::dp_cmd_t     cmd,
    input  mer_pkg::in_item_t    in_item,
    output mer_pkg::dp_status_t  status,
    output mer_pkg::pixel_t      pixel
);

    logic [mer_pkg::COORD_BITS-1:0]   a_reg, b_reg;
    logic [mer_pkg::COORD_BITS-1:0]   cx_reg, cy_reg;
    logic [mer_pkg::COLOR_W-1:0]      red_reg, green_reg, blue_reg;
    logic [mer_pkg::PT_W-1:0]         x_reg, y_reg;
    logic signed [mer_pkg::SLOPE_W-1:0] dx_reg, dy_reg;
    logic signed [mer_pkg::DEC_W-1:0] dec_reg, q_reg;
    logic [mer_pkg::SQ_W-1:0]         asq_reg, bsq_reg;
    logic [mer_pkg::PROD_W-1:0]       prod_reg;
    logic                             r2_reg;

    logic [mer_pkg::MUL_W-1:0]        mul_a, mul_b;
    logic [mer_pkg::PROD_W-1:0]       mul_p;
    logic [mer_pkg::MUL_W-1:0]        tx, ty_abs;
    logic signed [mer_pkg::SLOPE_W-1:0] dx_inc, dy_dec;
    logic signed [mer_pkg::DEC_W-1:0] dx_ext, dy_ext, asq_ext, bsq_ext;
    logic signed [mer_pkg::DEC_W-1:0] q_round;
    logic [mer_pkg::PIX_W-1:0]        cx_ext, cy_ext, x_ext, y_ext;

    // changeover operands: 2x+1 and |y-1|
    assign tx     = mer_pkg::MUL_W'({x_reg, 1'b1});
    assign ty_abs = (y_reg == '0) ? mer_pkg::MUL_W'(1) : mer_pkg::MUL_W'(y_reg - 1'b1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            mer_pkg::DP_ASQ: begin
                mul_a = mer_pkg::MUL_W'(a_reg);
                mul_b = mer_pkg::MUL_W'(a_reg);
            end
            mer_pkg::DP_BSQ: begin
                mul_a = mer_pkg::MUL_W'(b_reg);
                mul_b = mer_pkg::MUL_W'(b_reg);
            end
            mer_pkg::DP_BASQ: begin
                mul_a = mer_pkg::MUL_W'(b_reg);
                mul_b = mer_pkg::MUL_W'(asq_reg);
            end
            mer_pkg::DP_C1: begin
                mul_a = tx;
                mul_b = tx;
            end
            mer_pkg::DP_C2: begin
                mul_a = mer_pkg::MUL_W'(bsq_reg);
                mul_b = prod_reg[mer_pkg::MUL_W-1:0];
            end
            mer_pkg::DP_C3: begin
                mul_a = ty_abs;
                mul_b = ty_abs;
            end
            mer_pkg::DP_C4: begin
                mul_a = mer_pkg::MUL_W'(asq_reg);
                mul_b = prod_reg[mer_pkg::MUL_W-1:0];
            end
            mer_pkg::DP_C5: begin
                mul_a = mer_pkg::MUL_W'(asq_reg);
                mul_b = mer_pkg::MUL_W'(bsq_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dx_inc  = dx_reg + signed'(mer_pkg::SLOPE_W'({bsq_reg, 1'b0}));
    assign dy_dec  = dy_reg - signed'(mer_pkg::SLOPE_W'({asq_reg, 1'b0}));
    assign dx_ext  = mer_pkg::DEC_W'(dx_inc);
    assign dy_ext  = mer_pkg::DEC_W'(dy_dec);
    assign asq_ext = signed'(mer_pkg::DEC_W'(asq_reg));
    assign bsq_ext = signed'(mer_pkg::DEC_W'(bsq_reg));

    // divide by four rounding toward zero
    assign q_round = q_reg + signed'({{(mer_pkg::DEC_W-2){1'b0}},
                                      {2{q_reg[mer_pkg::DEC_W-1]}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r2_reg <= 1'b0;
        end else begin
            unique case (cmd.op)
                mer_pkg::DP_LOAD: r2_reg <= 1'b0;
                mer_pkg::DP_C7:   r2_reg <= 1'b1;
                default:          r2_reg <= r2_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            mer_pkg::DP_LOAD: begin
                a_reg     <= in_item.semi_axis_x;
                b_reg     <= in_item.semi_axis_y;
                cx_reg    <= in_item.center_x;
                cy_reg    <= in_item.center_y;
                red_reg   <= in_item.red;
                green_reg <= in_item.green;
                blue_reg  <= in_item.blue;
                x_reg     <= '0;
                y_reg     <= mer_pkg::PT_W'(in_item.semi_axis_y);
                dx_reg    <= '0;
            end
            mer_pkg::DP_ASQ: begin
                asq_reg <= mul_p[mer_pkg::SQ_W-1:0];
            end
            mer_pkg::DP_BSQ: begin
                bsq_reg <= mul_p[mer_pkg::SQ_W-1:0];
            end
            mer_pkg::DP_BASQ: begin
                prod_reg <= mul_p;
            end
            mer_pkg::DP_INIT: begin
                dec_reg <= bsq_ext - signed'(prod_reg)
                           + signed'(mer_pkg::DEC_W'(asq_reg >> 2));
                dy_reg  <= signed'(mer_pkg::SLOPE_W'({prod_reg, 1'b0}));
            end
            mer_pkg::DP_C1, mer_pkg::DP_C2, mer_pkg::DP_C4: begin
                prod_reg <= mul_p;
            end
            mer_pkg::DP_C3: begin
                q_reg    <= signed'(prod_reg);
                prod_reg <= mul_p;
            end
            mer_pkg::DP_C5: begin
                q_reg    <= q_reg + signed'(mer_pkg::DEC_W'({prod_reg, 2'b00}));
                prod_reg <= mul_p;
            end
            mer_pkg::DP_C6: begin
                q_reg <= q_reg - signed'(mer_pkg::DEC_W'({prod_reg, 2'b00}));
            end
            mer_pkg::DP_C7: begin
                dec_reg <= q_round >>> 2;
            end
            mer_pkg::DP_STEP: begin
                if (r2_reg) begin
                    y_reg  <= y_reg - 1'b1;
                    dy_reg <= dy_dec;
                    if (dec_reg[mer_pkg::DEC_W-1] || dec_reg == '0) begin
                        x_reg   <= x_reg + 1'b1;
                        dx_reg  <= dx_inc;
                        dec_reg <= dec_reg + asq_ext - dy_ext + dx_ext;
                    end else begin
                        dec_reg <= dec_reg + asq_ext - dy_ext;
                    end
                end else begin
                    x_reg  <= x_reg + 1'b1;
                    dx_reg <= dx_inc;
                    if (!dec_reg[mer_pkg::DEC_W-1]) begin
                        y_reg   <= y_reg - 1'b1;
                        dy_reg  <= dy_dec;
                        dec_reg <= dec_reg + bsq_ext + dx_ext - dy_ext;
                    end else begin
                        dec_reg <= dec_reg + bsq_ext + dx_ext;
                    end
                end
            end
            default: begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign status.r2       = r2_reg;
    assign status.dx_lt_dy = (dx_reg < dy_reg);
    assign status.y_zero   = (y_reg == '0);

    // mirror order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
    assign cx_ext = mer_pkg::PIX_W'(cx_reg);
    assign cy_ext = mer_pkg::PIX_W'(cy_reg);
    assign x_ext  = mer_pkg::PIX_W'(x_reg);
    assign y_ext  = mer_pkg::PIX_W'(y_reg);

    always_comb begin
        pixel.data.pixel_x = cmd.pix_idx[0] ? (cx_ext - x_ext) : (cx_ext + x_ext);
        pixel.data.pixel_y = cmd.pix_idx[1] ? (cy_ext - y_ext) : (cy_ext + y_ext);
        pixel.data.red     = red_reg;
        pixel.data.green   = green_reg;
        pixel.data.blue    = blue_reg;
        pixel.last         = (cmd.pix_idx == mer_pkg::LAST_PIX);
        pixel.done         = status.y_zero;
    end

endmodule

// ===== rtl/core/mer_out.sv =====
// Output register stage holding one pixel item toward the receiver.
`timescale 1ns / 1ps

module mer_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  mer_pkg::pixel_t  d,
    input  logic             m_ready,
    output logic             m_valid,
    output mer_pkg::pixel_t  q,
    output logic             load_ok
);

    logic            valid_reg;
    mer_pkg::pixel_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= d;
        end
    end

    assign load_ok = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign q       = data_reg;

endmodule
